### src/efc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efc_pkg
// Shared types and constants of the elevator floor controller.
// ----------------------------------------------------------------------------
package efc_pkg;

  localparam int ORDER_KINDS = 3;
  localparam int PENDING_W   = 12;
  localparam int FLOOR_W     = 2;
  localparam int TIMER_W     = 8;

  localparam logic [TIMER_W-1:0] TIMER_MAX   = 8'hFF;
  localparam logic [TIMER_W-1:0] TICKS_RESET = 8'd3;

  // order kinds within one floor row
  localparam logic [1:0] KIND_UP    = 2'd0;
  localparam logic [1:0] KIND_DOWN  = 2'd1;
  localparam logic [1:0] KIND_CABIN = 2'd2;

  // input beat kinds
  localparam logic CMD_STEP  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_RUN   = 2'd1,
    MODE_DOOR  = 2'd2,
    MODE_EMERG = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    MOTOR_STOP = 2'd0,
    MOTOR_UP   = 2'd1,
    MOTOR_DOWN = 2'd2
  } motor_t;

  typedef enum logic [3:0] {
    CS_READY,
    CS_APPLY,
    CS_INIT,
    CS_WALK,
    CS_DECIDE,
    CS_INIT2,
    CS_WALK2,
    CS_FIN2,
    CS_LOAD
  } ctrl_state_t;

  typedef struct packed {
    logic       command;
    logic       at_floor;
    logic [1:0] sensor_floor;
    logic       stop_pressed;
    logic       obstructed;
    logic       time_tick;
    logic [1:0] order_floor;
    logic [1:0] order_button;
    logic       order_value;
  } efc_in_t;

  typedef struct packed {
    logic [1:0]           fsm_state;
    logic [1:0]           motor_drive;
    logic                 door_lamp;
    logic                 stop_lamp;
    logic [FLOOR_W-1:0]   floor_indicator;
    logic                 travel_up;
    logic                 target_valid;
    logic [FLOOR_W-1:0]   target_floor;
    logic [PENDING_W-1:0] pending_orders;
  } efc_out_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;
    logic apply;
    logic scan_init;
    logic scan_step;
    logic decide;
    logic finish;
    logic load;
  } efc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic rescan;
  } efc_stat_t;

endpackage

### src/efc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efc_ctrl
// Sequencer: accepts a beat, steps the datapath through apply, scan, decide,
// an optional second scan, and loads the result register.
// ----------------------------------------------------------------------------
module efc_ctrl
  import efc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  efc_stat_t stat,
  output efc_cmd_t  cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != CS_READY);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= CS_READY;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      CS_READY: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = CS_APPLY;
        end
      end
      CS_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = CS_INIT;
      end
      CS_INIT: begin
        cmd.scan_init = 1'b1;
        state_nxt     = CS_WALK;
      end
      CS_WALK: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) state_nxt = CS_DECIDE;
      end
      CS_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = stat.rescan ? CS_INIT2 : CS_LOAD;
      end
      CS_INIT2: begin
        cmd.scan_init = 1'b1;
        state_nxt     = CS_WALK2;
      end
      CS_WALK2: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) state_nxt = CS_FIN2;
      end
      CS_FIN2: begin
        cmd.finish = 1'b1;
        state_nxt  = CS_LOAD;
      end
      CS_LOAD: begin
        if (out_free) begin
          cmd.load  = 1'b1;
          state_nxt = CS_READY;
        end
      end
      default: state_nxt = CS_READY;
    endcase
  end

  always_comb begin
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

endmodule

### src/efc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efc_datapath
// Order table, car state, door timer, the position walker of the
// collective scan and the result register.
// ----------------------------------------------------------------------------
module efc_datapath
  import efc_pkg::*;
#(
  parameter int FLOORS = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  efc_cmd_t             cmd,
  output efc_stat_t            stat,
  input  efc_in_t              in_data,
  input  logic                 cfg_wr_en,
  input  logic [TIMER_W-1:0]   cfg_wr_data,
  output efc_out_t             out_data
);

  localparam int TW  = ORDER_KINDS * FLOORS;
  localparam int IW  = $clog2(TW);
  localparam int FLW = $clog2(FLOORS);
  localparam int PW  = $clog2(2 * FLOORS);
  localparam int OW  = (TW < PENDING_W) ? TW : PENDING_W;
  localparam logic [PW-1:0] POS_LAST  = PW'(2 * FLOORS - 1);
  localparam logic [PW-1:0] POS_UPPER = PW'(FLOORS);

  // car state
  mode_t              mode_r, mode_nxt;
  logic [FLW-1:0]     lf_r, lf_nxt;
  logic               heading_r, heading_nxt;
  motor_t             motor_r, motor_nxt;
  logic               door_lamp_r, door_lamp_nxt;
  logic               stop_lamp_r, stop_lamp_nxt;
  logic [TW-1:0]      orders_r, orders_nxt;
  logic [TIMER_W-1:0] timer_r, timer_nxt;
  logic [TIMER_W-1:0] ticks_r, ticks_nxt;

  // beat and scan
  efc_in_t            item_r, item_nxt;
  logic [PW-1:0]      pos_r, pos_nxt;
  logic [PW-1:0]      cnt_r, cnt_nxt;
  logic               found_r, found_nxt;
  logic               short_r, short_nxt;
  logic               end_r, end_nxt;
  logic [FLW-1:0]     sfl_r, sfl_nxt;
  logic               tgt_valid_r, tgt_valid_nxt;
  logic [FLW-1:0]     tgt_floor_r, tgt_floor_nxt;
  efc_out_t           out_r, out_nxt;

  logic [IW-1:0]      lf_base;
  logic [IW-1:0]      walk_base;
  logic [IW-1:0]      wr_idx;
  logic [ORDER_KINDS-1:0] lf_row, walk_row;
  logic               walk_up;
  logic [FLW-1:0]     walk_fl;
  logic               walk_hit;
  logic [PW-1:0]      start_pos;
  logic               shortcut;
  logic               at;
  logic [FLW-1:0]     sf_fl;
  logic               at_next;
  logic               timeout;
  logic               heading_c;
  logic               wr_ok;
  logic               stop, obst;

  // pos counts 0..2n-1: first half walks up, second half walks down
  assign walk_up   = (pos_r < POS_UPPER);
  assign walk_fl   = walk_up ? FLW'(pos_r) : FLW'(POS_LAST - pos_r);
  assign walk_base = IW'(walk_fl) * IW'(ORDER_KINDS);
  assign walk_row  = orders_r[walk_base +: ORDER_KINDS];
  assign walk_hit  = walk_row[KIND_CABIN] | (walk_up ? walk_row[KIND_UP] : walk_row[KIND_DOWN]);

  assign lf_base   = IW'(lf_r) * IW'(ORDER_KINDS);
  assign lf_row    = orders_r[lf_base +: ORDER_KINDS];
  assign shortcut  = ((mode_r == MODE_IDLE) || (mode_r == MODE_DOOR)) && (lf_row != '0);

  always_comb begin
    if (heading_r) begin
      start_pos = PW'(lf_r) + PW'(1);
    end else if (lf_r == '0) begin
      start_pos = '0;
    end else begin
      start_pos = POS_LAST - PW'(lf_r) + PW'(1);
    end
  end

  assign wr_ok   = (int'(item_r.order_floor) < FLOORS) && (item_r.order_button <= KIND_CABIN);
  assign wr_idx  = IW'(item_r.order_floor) * IW'(ORDER_KINDS) + IW'(item_r.order_button);

  assign at      = item_r.at_floor && (int'(item_r.sensor_floor) < FLOORS);
  assign sf_fl   = FLW'(item_r.sensor_floor);
  assign at_next = at && found_r && (sfl_r == sf_fl);
  assign timeout = (timer_r >= ticks_r);
  assign stop    = item_r.stop_pressed;
  assign obst    = item_r.obstructed;
  assign heading_c = (found_r && !short_r) ? !(sfl_r < lf_r) : heading_r;

  assign stat.scan_done = found_r || end_r;
  assign stat.rescan    = (item_r.command == CMD_STEP) && (mode_r == MODE_DOOR) &&
                          !stop && !timeout;

  always_comb begin
    mode_nxt      = mode_r;
    lf_nxt        = lf_r;
    heading_nxt   = heading_r;
    motor_nxt     = motor_r;
    door_lamp_nxt = door_lamp_r;
    stop_lamp_nxt = stop_lamp_r;
    orders_nxt    = orders_r;
    timer_nxt     = timer_r;
    ticks_nxt     = ticks_r;
    item_nxt      = item_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    found_nxt     = found_r;
    short_nxt     = short_r;
    end_nxt       = end_r;
    sfl_nxt       = sfl_r;
    tgt_valid_nxt = tgt_valid_r;
    tgt_floor_nxt = tgt_floor_r;
    out_nxt       = out_r;

    if (cfg_wr_en) ticks_nxt = cfg_wr_data;

    if (cmd.latch) item_nxt = in_data;

    if (cmd.apply) begin
      if (item_r.command == CMD_WRITE) begin
        if (wr_ok) orders_nxt[wr_idx] = item_r.order_value;
      end else if (item_r.time_tick && (timer_r != TIMER_MAX)) begin
        timer_nxt = timer_r + TIMER_W'(1);
      end
    end

    if (cmd.scan_init) begin
      end_nxt = 1'b0;
      if (shortcut) begin
        found_nxt = 1'b1;
        short_nxt = 1'b1;
        sfl_nxt   = lf_r;
      end else begin
        found_nxt = 1'b0;
        short_nxt = 1'b0;
        pos_nxt   = start_pos;
        cnt_nxt   = '0;
      end
    end

    if (cmd.scan_step && !(found_r || end_r)) begin
      if (walk_hit) begin
        found_nxt = 1'b1;
        sfl_nxt   = walk_fl;
      end else if (cnt_r == POS_LAST) begin
        end_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + PW'(1);
        pos_nxt = (pos_r == POS_LAST) ? '0 : pos_r + PW'(1);
      end
    end

    if (cmd.decide) begin
      tgt_valid_nxt = found_r;
      tgt_floor_nxt = found_r ? sfl_r : '0;
      if (item_r.command == CMD_STEP) begin
        heading_nxt = heading_c;
        if (at) lf_nxt = sf_fl;
        unique case (mode_r)
          MODE_RUN, MODE_IDLE: begin
            if (stop) begin
              mode_nxt      = MODE_EMERG;
              motor_nxt     = MOTOR_STOP;
              stop_lamp_nxt = 1'b1;
              if (at) door_lamp_nxt = 1'b1;
            end else if (at_next) begin
              mode_nxt      = MODE_DOOR;
              motor_nxt     = MOTOR_STOP;
              door_lamp_nxt = 1'b1;
              timer_nxt     = '0;
            end else if ((mode_r == MODE_RUN) ? !(at && !found_r) : found_r) begin
              mode_nxt  = MODE_RUN;
              motor_nxt = heading_c ? MOTOR_UP : MOTOR_DOWN;
            end else begin
              // idle: a running car stops, an idle one stays as it is
              if (mode_r == MODE_RUN) motor_nxt = MOTOR_STOP;
              mode_nxt = MODE_IDLE;
            end
          end
          MODE_DOOR: begin
            if (stop) begin
              mode_nxt      = MODE_EMERG;
              motor_nxt     = MOTOR_STOP;
              stop_lamp_nxt = 1'b1;
              if (at) door_lamp_nxt = 1'b1;
            end else if (timeout) begin
              door_lamp_nxt = 1'b0;
              if (found_r) begin
                mode_nxt  = MODE_RUN;
                motor_nxt = heading_c ? MOTOR_UP : MOTOR_DOWN;
              end else begin
                mode_nxt = MODE_IDLE;
              end
            end else if (obst) begin
              timer_nxt = '0;
            end
          end
          MODE_EMERG: begin
            if (!stop) begin
              mode_nxt      = MODE_IDLE;
              stop_lamp_nxt = 1'b0;
              door_lamp_nxt = 1'b0;
            end
          end
          default: mode_nxt = mode_r;
        endcase
      end
    end

    // second scan of a door-open step: serve the current floor or set heading
    if (cmd.finish && found_r) begin
      if (short_r) begin
        orders_nxt[lf_base +: ORDER_KINDS] = '0;
        timer_nxt                          = '0;
      end else begin
        heading_nxt = !(sfl_r < lf_r);
      end
    end

    if (cmd.load) begin
      out_nxt.fsm_state       = mode_r;
      out_nxt.motor_drive     = motor_r;
      out_nxt.door_lamp       = door_lamp_r;
      out_nxt.stop_lamp       = stop_lamp_r;
      out_nxt.floor_indicator = FLOOR_W'(lf_r);
      out_nxt.travel_up       = heading_r;
      out_nxt.target_valid    = tgt_valid_r;
      out_nxt.target_floor    = FLOOR_W'(tgt_floor_r);
      out_nxt.pending_orders  = PENDING_W'(orders_r[OW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      lf_r        <= '0;
      heading_r   <= 1'b0;
      motor_r     <= MOTOR_STOP;
      door_lamp_r <= 1'b0;
      stop_lamp_r <= 1'b0;
      orders_r    <= '0;
      timer_r     <= '0;
      ticks_r     <= TICKS_RESET;
    end else begin
      mode_r      <= mode_nxt;
      lf_r        <= lf_nxt;
      heading_r   <= heading_nxt;
      motor_r     <= motor_nxt;
      door_lamp_r <= door_lamp_nxt;
      stop_lamp_r <= stop_lamp_nxt;
      orders_r    <= orders_nxt;
      timer_r     <= timer_nxt;
      ticks_r     <= ticks_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    pos_r       <= pos_nxt;
    cnt_r       <= cnt_nxt;
    found_r     <= found_nxt;
    short_r     <= short_nxt;
    end_r       <= end_nxt;
    sfl_r       <= sfl_nxt;
    tgt_valid_r <= tgt_valid_nxt;
    tgt_floor_r <= tgt_floor_nxt;
    out_r       <= out_nxt;
  end

  assign out_data = out_r;

endmodule

### src/elevator_floor_controller_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elevator_floor_controller_core
// Elevator controller with a collective up-then-down scan over FLOORS floors.
// ----------------------------------------------------------------------------
// One beat is handled at a time. After acceptance the beat is applied (order
// write or timer tick), then the next stop is found by walking up to 2*FLOORS
// scan positions one per cycle, then the state update runs and the result
// register loads. in_stall drops in the same cycle that out_valid rises, so no
// new beat is accepted before the last one is through.
// A step that keeps the door open walks the scan a second time. The walker is
// the pacing unit. A result waiting in the output register does not block
// acceptance of the next beat; only the final load waits for it to leave.
module elevator_floor_controller_core
  import efc_pkg::*;
#(
  parameter int FLOORS = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  efc_in_t            in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output efc_out_t           out_data,
  input  logic               cfg_wr_en,
  input  logic [TIMER_W-1:0] cfg_wr_data
);

  efc_cmd_t  cmd;
  efc_stat_t stat;

  efc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  efc_datapath #(
    .FLOORS (FLOORS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_data    (out_data)
  );

endmodule

### src/efc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efc_checker
// Port-level checks of the elevator floor controller, bound to the top level.
// ----------------------------------------------------------------------------
module efc_checker
  import efc_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input efc_out_t           out_data
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed under stall");

  // one beat in flight: input closes right after acceptance
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second beat accepted while busy");

  a_no_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.target_valid |-> out_data.target_floor == '0)
    else $error("target floor set without a target");

  // door open and emergency both keep the motor stopped with their lamp lit
  a_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_data.fsm_state == MODE_DOOR && !out_data.door_lamp) ||
                  (out_data.fsm_state == MODE_EMERG && !out_data.stop_lamp) ||
                  ((out_data.fsm_state == MODE_DOOR || out_data.fsm_state == MODE_EMERG) &&
                   out_data.motor_drive != MOTOR_STOP)) |-> 1'b0)
    else $error("car not held in door-open or emergency state");

endmodule

bind elevator_floor_controller_core efc_checker u_efc_checker (.*);
